@@ design/etbw_pkg.sv @@
// ----------------------------------------------------------------------------
// Extent table package
// Request and result types and shared constants for the extent table core.
// ----------------------------------------------------------------------------
package etbw_pkg;

    localparam int N_CHAIN = 4;
    localparam int MAX_EXT = 16;
    localparam int BLOCK_W = 32;
    localparam int TOTAL_W = 40;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_REWIND = 2'd2;
    localparam logic [1:0] ACT_NEXT   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EXHAUST = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         chain_index;
        logic [BLOCK_W-1:0] start_block;
        logic [BLOCK_W-1:0] end_block;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [BLOCK_W-1:0] block_number;
        logic [4:0]         extent_count;
        logic [TOTAL_W-1:0] total_blocks;
    } t_rsp;

endpackage

@@ design/etbw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module etbw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/extent_table_with_block_walker_core.sv @@
// ----------------------------------------------------------------------------
// Extent table with block walker
// Sorted extent chains with coalescing insert, clear and a block walker.
// ----------------------------------------------------------------------------
// Each entry that add searches or moves is read through the one read port.
// One request at a time; the next is taken while the result is strobed.
// Result strobed for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears counts, totals and walker, and sets the config register to 4.
// ----------------------------------------------------------------------------
module extent_table_with_block_walker_core
    import etbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_strobe,
    output t_rsp       o_rsp,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);
    localparam int CW    = $clog2(N_CHAIN);
    localparam int EW    = $clog2(MAX_EXT);
    localparam int NW    = $clog2(MAX_EXT + 1);
    localparam int AW    = CW + EW;
    localparam int WCW   = $clog2(N_CHAIN + 2);
    localparam int SW    = TOTAL_W + 1;
    localparam int DEPTH = N_CHAIN * MAX_EXT;
    localparam logic [TOTAL_W-1:0] TMAX  = '1;
    localparam logic [BLOCK_W-1:0] ONE_B = BLOCK_W'(1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SRD  = 5'd1;
    localparam logic [4:0] S_SCMP = 5'd2;
    localparam logic [4:0] S_DEC  = 5'd3;
    localparam logic [4:0] S_MRG  = 5'd4;
    localparam logic [4:0] S_MCHK = 5'd5;
    localparam logic [4:0] S_DNRD = 5'd6;
    localparam logic [4:0] S_DNWR = 5'd7;
    localparam logic [4:0] S_UPRD = 5'd8;
    localparam logic [4:0] S_UPWR = 5'd9;
    localparam logic [4:0] S_INS  = 5'd10;
    localparam logic [4:0] S_WLK  = 5'd11;
    localparam logic [4:0] S_WCMP = 5'd12;
    localparam logic [4:0] S_WCHK = 5'd13;
    localparam logic [4:0] S_WFRD = 5'd14;
    localparam logic [4:0] S_WFST = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    logic [4:0]         r_state;
    logic [1:0]         r_chain;
    logic [BLOCK_W-1:0] r_first, r_last;
    logic [NW-1:0]      r_cnt [N_CHAIN];
    logic [TOTAL_W-1:0] r_tot [N_CHAIN];
    logic [2:0]         r_ciu;
    logic [WCW-1:0]     r_wchain;
    logic [EW-1:0]      r_wext;
    logic               r_wvalid;
    logic [BLOCK_W-1:0] r_woff;
    logic [NW-1:0]      r_pos, r_i;
    logic [1:0]         r_status;
    logic [BLOCK_W-1:0] r_block;
    logic [BLOCK_W-1:0] r_prev_last;

    logic               we;
    logic               wf_en;
    logic [AW-1:0]      waddr, raddr;
    logic [BLOCK_W-1:0] wf, wl, rf, rl;

    etbw_ram #(.WIDTH(BLOCK_W), .DEPTH(DEPTH)) u_first (
        .i_clk(i_clk), .i_we(we & wf_en), .i_waddr(waddr), .i_wdata(wf),
        .i_raddr(raddr), .o_rdata(rf)
    );
    etbw_ram #(.WIDTH(BLOCK_W), .DEPTH(DEPTH)) u_last (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wl),
        .i_raddr(raddr), .o_rdata(rl)
    );

    logic           cok;
    logic [CW-1:0]  cidx;
    logic [NW-1:0]  n;
    logic [NW-1:0]  pos_m1, pos_p1, i_m1, i_p1, wext_p1;
    logic [WCW-1:0] wchain_m1;
    logic [CW-1:0]  wcur;
    logic [WCW-1:0] limit;
    logic           touch;

    assign cok       = 32'(r_chain) < 32'(N_CHAIN);
    assign cidx      = CW'(r_chain);
    assign n         = r_cnt[cidx];
    assign pos_m1    = r_pos - NW'(1);
    assign pos_p1    = r_pos + NW'(1);
    assign i_m1      = r_i - NW'(1);
    assign i_p1      = r_i + NW'(1);
    assign wext_p1   = NW'(r_wext) + NW'(1);
    assign wchain_m1 = r_wchain - WCW'(1);
    assign wcur      = wchain_m1[CW-1:0];
    assign limit     = (r_ciu > 3'(N_CHAIN)) ? WCW'(N_CHAIN) : WCW'(r_ciu);
    assign touch     = (r_last + ONE_B) == rf;

    function automatic logic [AW-1:0] addr(input logic [CW-1:0] c, input logic [EW-1:0] e);
        return {c, e};
    endfunction

    // saturating add of extent length
    logic [BLOCK_W-1:0] diff;
    logic [SW-1:0]      sum;
    logic [TOTAL_W-1:0] newtot;
    assign diff = r_last - r_first;
    assign sum  = {1'b0, r_tot[cidx]} + SW'(diff) + SW'(1);
    always_comb begin
        if (r_last < r_first) begin
            newtot = r_tot[cidx];
        end else if (sum[TOTAL_W]) begin
            newtot = TMAX;
        end else begin
            newtot = sum[TOTAL_W-1:0];
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        we    = 1'b0;
        wf_en = 1'b1;
        waddr = addr(cidx, r_pos[EW-1:0]);
        wf    = r_first;
        wl    = r_last;
        raddr = addr(cidx, r_i[EW-1:0]);
        unique case (r_state) inside
            S_MRG: begin
                we = 1'b1; wf_en = 1'b0;
                waddr = addr(cidx, pos_m1[EW-1:0]);
                raddr = addr(cidx, r_pos[EW-1:0]);
            end
            S_MCHK: begin
                // absorb following extent
                we = touch; wf_en = 1'b0;
                waddr = addr(cidx, pos_m1[EW-1:0]);
                wl = rl;
            end
            S_DNWR: begin
                we = 1'b1; waddr = addr(cidx, i_m1[EW-1:0]); wf = rf; wl = rl;
            end
            S_UPWR: begin
                we = 1'b1; waddr = addr(cidx, i_p1[EW-1:0]); wf = rf; wl = rl;
            end
            S_INS: we = 1'b1;
            S_WLK, S_WFRD: raddr = addr(wcur, r_wext);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
            r_state  <= S_IDLE;
            r_ciu    <= 3'd4;
            r_wchain <= '0; r_wext <= '0; r_wvalid <= 1'b0; r_woff <= '0;
            for (int k = 0; k < N_CHAIN; k++) begin
                r_cnt[k] <= '0; r_tot[k] <= '0;
            end
        end else begin
            o_strobe <= (r_state == S_DONE);
            if (i_cfg_valid && o_cfg_ready) r_ciu <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_chain <= i_req.chain_index; r_status <= ST_OK; r_block <= '0;
                        r_first <= i_req.start_block;
                        r_last  <= i_req.end_block;
                        r_i <= '0;
                        unique case (i_req.action)
                            ACT_ADD: r_state <= (32'(i_req.chain_index) < 32'(N_CHAIN))
                                                ? S_SRD : S_DONE;
                            ACT_CLEAR: begin
                                if (32'(i_req.chain_index) < 32'(N_CHAIN)) begin
                                    r_cnt[CW'(i_req.chain_index)] <= '0;
                                    r_tot[CW'(i_req.chain_index)] <= '0;
                                end
                                r_state <= S_DONE;
                            end
                            ACT_REWIND: begin
                                r_wchain <= '0; r_wext <= '0; r_wvalid <= 1'b0;
                                r_woff <= '0;
                                r_state <= S_DONE;
                            end
                            ACT_NEXT: r_state <= S_WLK;
                        endcase
                    end
                end
                S_SRD: r_state <= (r_i < n) ? S_SCMP : S_DEC;
                S_SCMP: begin
                    if (rf < r_first) begin
                        r_prev_last <= rl; r_i <= i_p1; r_state <= S_SRD;
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_pos <= r_i;
                    if (r_i != '0 && r_prev_last == r_first - ONE_B) begin
                        r_state <= S_MRG;
                    end else if (n >= NW'(MAX_EXT)) begin
                        r_status <= ST_FULL; r_state <= S_DONE;
                    end else if (r_i == n) begin
                        r_state <= S_INS;
                    end else begin
                        r_i <= n - NW'(1); r_state <= S_UPRD;
                    end
                end
                S_MRG: begin
                    r_tot[cidx] <= newtot;
                    r_state <= (r_pos >= n) ? S_DONE : S_MCHK;
                end
                S_MCHK: begin
                    if (!touch) begin
                        r_state <= S_DONE;
                    end else if (pos_p1 >= n) begin
                        r_cnt[cidx] <= n - NW'(1); r_state <= S_DONE;
                    end else begin
                        r_i <= pos_p1; r_state <= S_DNRD;
                    end
                end
                S_DNRD: r_state <= S_DNWR;
                S_DNWR: begin
                    if (i_p1 >= n) begin
                        r_cnt[cidx] <= n - NW'(1); r_state <= S_DONE;
                    end else begin
                        r_i <= i_p1; r_state <= S_DNRD;
                    end
                end
                S_UPRD: r_state <= S_UPWR;
                S_UPWR: begin
                    if (r_i == r_pos) begin
                        r_state <= S_INS;
                    end else begin
                        r_i <= i_m1; r_state <= S_UPRD;
                    end
                end
                S_INS: begin
                    r_cnt[cidx] <= n + NW'(1);
                    r_tot[cidx] <= newtot;
                    r_state <= S_DONE;
                end
                S_WLK: begin
                    if (r_wchain != '0 && wchain_m1 >= limit) begin
                        r_status <= ST_EXHAUST; r_state <= S_DONE;
                    end else if (r_wvalid) begin
                        if (r_wchain == '0 || NW'(r_wext) >= r_cnt[wcur]) begin
                            r_wvalid <= 1'b0; r_woff <= '0; r_state <= S_WCHK;
                        end else begin
                            r_state <= S_WCMP;
                        end
                    end else begin
                        r_state <= S_WCHK;
                    end
                end
                S_WCMP: begin
                    if (r_woff == rl) begin
                        if (wext_p1 < r_cnt[wcur]) begin
                            r_wext <= r_wext + EW'(1); r_state <= S_WFRD;
                        end else begin
                            r_wvalid <= 1'b0; r_wext <= '0; r_woff <= '0;
                            r_state <= S_WCHK;
                        end
                    end else begin
                        r_woff <= r_woff + ONE_B; r_block <= r_woff + ONE_B;
                        r_state <= S_DONE;
                    end
                end
                S_WCHK: begin
                    if (r_wchain >= limit) begin
                        r_wchain <= limit + WCW'(1);
                        r_status <= ST_EXHAUST; r_state <= S_DONE;
                    end else begin
                        r_wchain <= r_wchain + WCW'(1);
                        if (r_cnt[r_wchain[CW-1:0]] != '0) begin
                            r_wext <= '0; r_state <= S_WFRD;
                        end
                    end
                end
                S_WFRD: r_state <= S_WFST;
                S_WFST: begin
                    r_woff <= rf; r_block <= rf; r_wvalid <= 1'b1; r_state <= S_DONE;
                end
                S_DONE: begin
                    o_rsp.status       <= r_status;
                    o_rsp.block_number <= r_block;
                    o_rsp.extent_count <= cok ? r_cnt[cidx] : '0;
                    o_rsp.total_blocks <= cok ? r_tot[cidx] : '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_strobe |=> !o_strobe)
        else $error("double strobe");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) start && !busy |=> busy)
        else $error("request not taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_strobe |-> !busy)
        else $error("strobe while busy");
endmodule
